FILE: rtl/core/ibmw_pkg.sv
// Shared codes and types for the indirect block map walker.
package ibmw_pkg;

   // request opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REPLY  = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // pointer slots
   localparam int unsigned SLOT_COUNT  = 15;
   localparam logic [3:0]  SLOT_SINGLE = 4'd12;
   localparam logic [3:0]  SLOT_DOUBLE = 4'd13;
   localparam logic [3:0]  SLOT_TRIPLE = 4'd14;

   // largest supported log block size
   localparam logic [1:0] LBS_MAX = 2'd2;

   typedef enum logic [2:0] {
      REGION_DIRECT,
      REGION_SINGLE,
      REGION_DOUBLE,
      REGION_TRIPLE,
      REGION_BEYOND
   } region_type;

endpackage

FILE: rtl/core/ibmw_if.sv
// Request and response channel interfaces of the block map walker.
interface ibmw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  slot;
   logic [31:0] value;

   modport source (output valid, output opcode, output slot, output value, input ready);
   modport sink   (input valid, input opcode, input slot, input value, output ready);
endinterface

interface ibmw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] read_block;
   logic [9:0]  read_index;
   logic [31:0] phys_block;
   logic        unmapped;

   modport source (output valid, output result_kind, output read_block, output read_index,
                   output phys_block, output unmapped, input ready);
   modport sink   (input valid, input result_kind, input read_block, input read_index,
                   input phys_block, input unmapped, output ready);
endinterface

FILE: rtl/core/indirect_block_map_walker_top.sv
// Indirect block map walker: pointer table memory, walk state and response register.
//
// Maps a logical block number to a physical block through a 15-slot pointer table
// (direct slots, then single, double and triple indirect). Load beats write a slot
// and can be taken back to back while no beat is held and the response side keeps
// up. A lookup or reply beat is held while the pointer memory is read (synchronous
// read), then lands in the response register; the next request beat is taken once
// the held beat is gone and the response register is free or being drained.
// A walk issues up to three read beats; each must be answered by a reply beat
// carrying the pointer word. Zero pointers or zero replies end the walk unmapped.
// The block size register may only change while no beat is in flight.
module indirect_block_map_walker_top #(
   parameter int DIRECT_POINTERS    = 12,
   parameter int BLOCK_NUMBER_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   ibmw_req_if.sink          req_if,
   ibmw_rsp_if.source        rsp_if
);

   localparam logic [32:0] DIRECT_END = 33'(DIRECT_POINTERS);

   // configuration
   logic [1:0] log_block_size_ff;
   logic [1:0] lbs_eff;

   // pointer table
   logic [BLOCK_NUMBER_WIDTH-1:0] ptr_mem [ibmw_pkg::SLOT_COUNT];
   logic [BLOCK_NUMBER_WIDTH-1:0] ptr_rdata_ff;
   logic [3:0]                    rd_addr;

   // accept side
   logic                   req_accept;
   logic                   load_accept;
   logic                   work_accept;
   ibmw_pkg::region_type   region;
   logic [31:0]            base;
   logic [4:0]             word_shift;
   logic [32:0]            single_end;
   logic [32:0]            double_end;
   logic [32:0]            triple_end;

   // beat held for one cycle while the table read completes
   logic                   pend_ff;
   logic                   pend_is_reply_ff;
   ibmw_pkg::region_type   pend_region_ff;
   logic [31:0]            pend_value_ff;
   logic [31:0]            pend_base_ff;

   // walk state
   logic        walk_active_ff, walk_active_in;
   logic [1:0]  walk_level_ff, walk_level_in;
   logic [31:0] residual_ff, residual_in;

   // response register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_block_ff, rsp_block_in;
   logic [9:0]  rsp_index_ff, rsp_index_in;
   logic [31:0] rsp_phys_ff, rsp_phys_in;
   logic        rsp_unmapped_ff, rsp_unmapped_in;

   // resolve-stage helpers
   logic [31:0] top_ptr;
   logic [31:0] reply_word;
   logic [31:0] lookup_residual;
   logic [1:0]  lookup_depth;

   function automatic logic [9:0] word_index(input logic [31:0] res, input logic [1:0] lvl,
                                             input logic [1:0] lbs);
      logic [3:0]  s;
      logic [4:0]  amt;
      logic [9:0]  mask;
      logic [31:0] shifted;
      case (lbs)
         2'd0: begin
            s    = 4'd8;
            mask = 10'h0FF;
         end
         2'd1: begin
            s    = 4'd9;
            mask = 10'h1FF;
         end
         default: begin
            s    = 4'd10;
            mask = 10'h3FF;
         end
      endcase
      amt     = 5'(s * lvl);
      shifted = res >> amt;
      return shifted[9:0] & mask;
   endfunction

   assign lbs_eff = (log_block_size_ff > ibmw_pkg::LBS_MAX) ? ibmw_pkg::LBS_MAX
                                                            : log_block_size_ff;

   assign req_if.ready = !pend_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;
   assign load_accept  = req_accept && (req_if.opcode == ibmw_pkg::OP_LOAD);
   assign work_accept  = req_accept && ((req_if.opcode == ibmw_pkg::OP_LOOKUP) ||
                                        (req_if.opcode == ibmw_pkg::OP_REPLY));

   always_ff @(posedge clock) begin
      if (reset) begin
         log_block_size_ff <= 2'd0;
      end else if (csr_wr_en) begin
         log_block_size_ff <= csr_wr_data;
      end
   end

   // tree boundaries for the current block size
   always_comb begin
      word_shift = 5'd8 + 5'(lbs_eff);
      single_end = DIRECT_END + (33'd1 << word_shift);
      double_end = single_end + (33'd1 << (word_shift << 1));
      triple_end = double_end + (33'd1 << (5'(word_shift * 2'd3)));
   end

   always_comb begin
      region  = ibmw_pkg::REGION_BEYOND;
      base    = 32'd0;
      rd_addr = ibmw_pkg::SLOT_TRIPLE;
      if ({1'b0, req_if.value} < DIRECT_END) begin
         region  = ibmw_pkg::REGION_DIRECT;
         rd_addr = req_if.value[3:0];
      end else if ({1'b0, req_if.value} < single_end) begin
         region  = ibmw_pkg::REGION_SINGLE;
         base    = DIRECT_END[31:0];
         rd_addr = ibmw_pkg::SLOT_SINGLE;
      end else if ({1'b0, req_if.value} < double_end) begin
         region  = ibmw_pkg::REGION_DOUBLE;
         base    = single_end[31:0];
         rd_addr = ibmw_pkg::SLOT_DOUBLE;
      end else if ({1'b0, req_if.value} < triple_end) begin
         region  = ibmw_pkg::REGION_TRIPLE;
         base    = double_end[31:0];
         rd_addr = ibmw_pkg::SLOT_TRIPLE;
      end
   end

   always_ff @(posedge clock) begin
      if (load_accept && (req_if.slot < 4'(ibmw_pkg::SLOT_COUNT))) begin
         ptr_mem[req_if.slot] <= req_if.value[BLOCK_NUMBER_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (work_accept && (req_if.opcode == ibmw_pkg::OP_LOOKUP)) begin
         ptr_rdata_ff <= ptr_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= work_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (work_accept) begin
         pend_is_reply_ff <= (req_if.opcode == ibmw_pkg::OP_REPLY);
         pend_region_ff   <= region;
         pend_value_ff    <= req_if.value;
         pend_base_ff     <= base;
      end
   end

   assign top_ptr         = 32'(ptr_rdata_ff);
   assign reply_word      = 32'(pend_value_ff[BLOCK_NUMBER_WIDTH-1:0]);
   assign lookup_residual = pend_value_ff - pend_base_ff;

   always_comb begin
      case (pend_region_ff)
         ibmw_pkg::REGION_DOUBLE: lookup_depth = 2'd1;
         ibmw_pkg::REGION_TRIPLE: lookup_depth = 2'd2;
         default:                 lookup_depth = 2'd0;
      endcase
   end

   // resolve the held beat against the walk state
   always_comb begin
      walk_active_in  = walk_active_ff;
      walk_level_in   = walk_level_ff;
      residual_in     = residual_ff;
      rsp_kind_in     = ibmw_pkg::KIND_REJECT;
      rsp_block_in    = 32'd0;
      rsp_index_in    = 10'd0;
      rsp_phys_in     = 32'd0;
      rsp_unmapped_in = 1'b0;
      if (pend_ff) begin
         if (!pend_is_reply_ff) begin
            if (!walk_active_ff) begin
               rsp_kind_in = ibmw_pkg::KIND_DONE;
               case (pend_region_ff)
                  ibmw_pkg::REGION_DIRECT: begin
                     rsp_phys_in     = top_ptr;
                     rsp_unmapped_in = (top_ptr == 32'd0);
                  end
                  ibmw_pkg::REGION_SINGLE,
                  ibmw_pkg::REGION_DOUBLE,
                  ibmw_pkg::REGION_TRIPLE: begin
                     if (top_ptr == 32'd0) begin
                        rsp_unmapped_in = 1'b1;
                     end else begin
                        walk_active_in = 1'b1;
                        walk_level_in  = lookup_depth;
                        residual_in    = lookup_residual;
                        rsp_kind_in    = ibmw_pkg::KIND_READ;
                        rsp_block_in   = top_ptr;
                        rsp_index_in   = word_index(lookup_residual, lookup_depth, lbs_eff);
                     end
                  end
                  default: begin
                     rsp_unmapped_in = 1'b1;
                  end
               endcase
            end
         end else if (walk_active_ff) begin
            if ((reply_word == 32'd0) || (walk_level_ff == 2'd0)) begin
               walk_active_in  = 1'b0;
               rsp_kind_in     = ibmw_pkg::KIND_DONE;
               rsp_phys_in     = reply_word;
               rsp_unmapped_in = (reply_word == 32'd0);
            end else begin
               walk_level_in = walk_level_ff - 2'd1;
               rsp_kind_in   = ibmw_pkg::KIND_READ;
               rsp_block_in  = reply_word;
               rsp_index_in  = word_index(residual_ff, walk_level_ff - 2'd1, lbs_eff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_active_ff <= 1'b0;
         walk_level_ff  <= 2'd0;
         residual_ff    <= 32'd0;
      end else begin
         walk_active_ff <= walk_active_in;
         walk_level_ff  <= walk_level_in;
         residual_ff    <= residual_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_kind_ff     <= rsp_kind_in;
         rsp_block_ff    <= rsp_block_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_phys_ff     <= rsp_phys_in;
         rsp_unmapped_ff <= rsp_unmapped_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = rsp_kind_ff;
   assign rsp_if.read_block  = rsp_block_ff;
   assign rsp_if.read_index  = rsp_index_ff;
   assign rsp_if.phys_block  = rsp_phys_ff;
   assign rsp_if.unmapped    = rsp_unmapped_ff;

`ifndef SYNTHESIS
   // every lookup or reply beat is held, then reaches the response register
   a_pend_to_rsp: assert property (@(posedge clock) disable iff (reset)
      work_accept |=> pend_ff ##1 rsp_valid_ff)
      else $error("held beat did not reach the response register");

   // a read beat leaves a walk waiting for its reply
   a_read_means_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == ibmw_pkg::KIND_READ)) |-> walk_active_ff)
      else $error("read beat without an active walk");

   // completion flags unmapped exactly when the physical block is zero
   a_done_unmapped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == ibmw_pkg::KIND_DONE)) |->
         (rsp_unmapped_ff == (rsp_phys_ff == 32'd0)))
      else $error("unmapped flag disagrees with physical block");

   // a completion always ends the walk
   a_done_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && (rsp_kind_in == ibmw_pkg::KIND_DONE)) |=> !walk_active_ff)
      else $error("walk still active after completion");
`endif

endmodule

FILE: tb/tb_indirect_block_map_walker_top.sv
// Self-checking testbench for the indirect block map walker.
module tb_indirect_block_map_walker_top;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DIRECT_PTRS = 12;
   localparam int unsigned PHASE_BEATS = 105;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned EXP_SIDE = 0;   // state copy tracking accepted beats
   localparam int unsigned GEN_SIDE = 1;   // state copy tracking generated beats
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [3:0] SLOT_UNUSED = 4'd15;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  slot;
      logic [31:0] value;
   } map_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] read_block;
      logic [9:0]  read_index;
      logic [31:0] phys_block;
      logic        unmapped;
   } map_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_en_q    = 1'b0;
   logic [1:0]  csr_data_q  = 2'd0;
   logic        req_valid_q = 1'b0;
   map_req_type req_beat_q  = '0;
   logic        rsp_ready_q = 1'b0;

   ibmw_req_if req_if ();
   ibmw_rsp_if rsp_if ();

   assign req_if.valid  = req_valid_q;
   assign req_if.opcode = req_beat_q.opcode;
   assign req_if.slot   = req_beat_q.slot;
   assign req_if.value  = req_beat_q.value;
   assign rsp_if.ready  = rsp_ready_q;

   indirect_block_map_walker_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_en_q),
      .csr_wr_data (csr_data_q),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // two copies of the walker state: one follows accepted beats, one the generator
   logic [31:0] slot_ptr [2][15];
   bit          walk_on  [2] = '{0, 0};
   int unsigned walk_lvl [2] = '{0, 0};
   logic [31:0] walk_rem [2] = '{0, 0};
   logic [1:0]  blk_log  [2] = '{0, 0};

   map_req_type pending_beats [$];
   map_rsp_type expected_maps [$];
   int unsigned beats_made  = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   function automatic int unsigned word_bits(input int unsigned cp);
      return 8 + ((blk_log[cp] > ibmw_pkg::LBS_MAX) ? int'(ibmw_pkg::LBS_MAX)
                                                     : int'(blk_log[cp]));
   endfunction

   // Advance one state copy by a beat; returns 1 when the beat yields a response.
   function automatic bit walk_step(input int unsigned cp, input map_req_type beat,
                                    output map_rsp_type res);
      int unsigned     s;
      longint unsigned per;
      longint unsigned r;
      logic [31:0]     top;
      logic [31:0]     nxt;
      bit              issue;
      s     = word_bits(cp);
      per   = 64'd1 << s;
      res   = '0;
      issue = 1'b0;
      top   = '0;
      case (beat.opcode)
         ibmw_pkg::OP_LOAD: begin
            if (beat.slot != SLOT_UNUSED) slot_ptr[cp][beat.slot] = beat.value;
            return 1'b0;
         end
         ibmw_pkg::OP_LOOKUP: begin
            r = {32'd0, beat.value};
            if (walk_on[cp]) begin
               res.kind = ibmw_pkg::KIND_REJECT;
               return 1'b1;
            end
            if (r < DIRECT_PTRS) begin
               res.kind = ibmw_pkg::KIND_DONE;
               res.phys_block = slot_ptr[cp][r[3:0]];
               res.unmapped = (res.phys_block == 0);
               return 1'b1;
            end
            r -= DIRECT_PTRS;
            if (r < per) begin
               top = slot_ptr[cp][ibmw_pkg::SLOT_SINGLE];
               walk_lvl[cp] = 0;
               issue = 1'b1;
            end else begin
               r -= per;
               if (r < per * per) begin
                  top = slot_ptr[cp][ibmw_pkg::SLOT_DOUBLE];
                  walk_lvl[cp] = 1;
                  issue = 1'b1;
               end else begin
                  r -= per * per;
                  if (r < per * per * per) begin
                     top = slot_ptr[cp][ibmw_pkg::SLOT_TRIPLE];
                     walk_lvl[cp] = 2;
                     issue = 1'b1;
                  end
               end
            end
            // beyond triple reach, or a zero top pointer: unmapped at once
            if (!issue || top == 0) begin
               res.kind = ibmw_pkg::KIND_DONE;
               res.unmapped = 1'b1;
               return 1'b1;
            end
            walk_on[cp]  = 1'b1;
            walk_rem[cp] = r[31:0];
            nxt = top;
         end
         ibmw_pkg::OP_REPLY: begin
            if (!walk_on[cp]) begin
               res.kind = ibmw_pkg::KIND_REJECT;
               return 1'b1;
            end
            if (beat.value == 0 || walk_lvl[cp] == 0) begin
               walk_on[cp] = 1'b0;
               res.kind = ibmw_pkg::KIND_DONE;
               res.phys_block = beat.value;
               res.unmapped = (beat.value == 0);
               return 1'b1;
            end
            walk_lvl[cp] = walk_lvl[cp] - 1;
            nxt = beat.value;
         end
         default: return 1'b0;
      endcase
      res.kind = ibmw_pkg::KIND_READ;
      res.read_block = nxt;
      res.read_index = 10'((walk_rem[cp] >> (s * walk_lvl[cp])) & ((32'd1 << s) - 1));
      return 1'b1;
   endfunction

   // mostly zero, some short, a few long; calm stretches have none
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // ---------------- request driver ----------------
   bit          req_busy = 1'b0;
   bit          req_calm = 1'b0;
   int unsigned req_gap  = 0;

   always @(posedge clock) begin
      map_req_type beat;
      map_rsp_type res;
      if (!reset && req_if.valid && req_if.ready) begin
         beat = pending_beats.pop_front();
         if (walk_step(EXP_SIDE, beat, res)) expected_maps.push_back(res);
         req_busy = 1'b0;
         if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         req_gap = pick_gap(req_calm);
      end
   end

   always @(negedge clock) begin
      if (!req_busy) begin
         if (req_gap > 0) begin
            req_valid_q <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_beats.size() > 0) begin
            req_beat_q  <= pending_beats[0];
            req_valid_q <= 1'b1;
            req_busy = 1'b1;
         end else begin
            req_valid_q <= 1'b0;
         end
      end
   end

   // ---------------- response monitor ----------------
   bit          rsp_calm  = 1'b0;
   int unsigned rsp_stall = 0;

   always @(posedge clock) begin
      map_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_maps.size() == 0) begin
            $display("%0t: unexpected response beat, kind %0d", $time, rsp_if.result_kind);
            error_count++;
         end else begin
            want = expected_maps.pop_front();
            if (rsp_if.result_kind !== want.kind) begin
               $display("%0t: result_kind expected %0d, got %0d", $time, want.kind,
                        rsp_if.result_kind);
               error_count++;
            end
            if (rsp_if.read_block !== want.read_block) begin
               $display("%0t: read_block expected %h, got %h", $time, want.read_block,
                        rsp_if.read_block);
               error_count++;
            end
            if (rsp_if.read_index !== want.read_index) begin
               $display("%0t: read_index expected %0d, got %0d", $time, want.read_index,
                        rsp_if.read_index);
               error_count++;
            end
            if (rsp_if.phys_block !== want.phys_block) begin
               $display("%0t: phys_block expected %h, got %h", $time, want.phys_block,
                        rsp_if.phys_block);
               error_count++;
            end
            if (rsp_if.unmapped !== want.unmapped) begin
               $display("%0t: unmapped expected %0d, got %0d", $time, want.unmapped,
                        rsp_if.unmapped);
               error_count++;
            end
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         rsp_stall = pick_gap(rsp_calm);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ready_q <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ready_q <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic queue_beat(input logic [1:0] op, input logic [3:0] slot,
                             input logic [31:0] value);
      map_req_type beat;
      map_rsp_type unused;
      beat.opcode = op;
      beat.slot   = slot;
      beat.value  = value;
      pending_beats.push_back(beat);
      void'(walk_step(GEN_SIDE, beat, unused));
      if (op != OP_UNUSED && !(op == ibmw_pkg::OP_LOAD && slot == SLOT_UNUSED)) beats_made++;
   endtask

   task automatic cfg_write(input logic [1:0] lbs);
      @(negedge clock);
      csr_en_q   <= 1'b1;
      csr_data_q <= lbs;
      @(negedge clock);
      csr_en_q <= 1'b0;
      blk_log[EXP_SIDE] = lbs;
      blk_log[GEN_SIDE] = lbs;
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || expected_maps.size() != 0) @(posedge clock);
      // loads give no response and may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // region edges are hit often
   function automatic logic [31:0] pick_in(input longint unsigned lo,
                                           input longint unsigned span);
      case ($urandom_range(0, 4))
         0: return lo[31:0];
         1: return 32'(lo + span - 1);
         default: return 32'(lo + $urandom_range(0, 32'(span - 1)));
      endcase
   endfunction

   function automatic logic [31:0] reply_word();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic gen_walk();
      longint unsigned per;
      longint unsigned lo;
      int unsigned     r;
      logic [31:0]     lbn;
      per = 64'd1 << word_bits(GEN_SIDE);
      r   = $urandom_range(0, 99);
      if (r < 10) begin
         lbn = $urandom_range(0, DIRECT_PTRS - 1);
      end else if (r < 30) begin
         lbn = pick_in(DIRECT_PTRS, per);
      end else if (r < 55) begin
         lbn = pick_in(DIRECT_PTRS + per, per * per);
      end else if (r < 85) begin
         lbn = pick_in(DIRECT_PTRS + per + per * per, per * per * per);
      end else begin
         lo = DIRECT_PTRS + per + per * per + per * per * per;
         lbn = pick_in(lo, 64'h1_0000_0000 - lo);
      end
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'($urandom_range(0, 15)), lbn);
      while (walk_on[GEN_SIDE]) begin
         case ($urandom_range(0, 19))
            0: queue_beat(ibmw_pkg::OP_LOOKUP, 4'($urandom_range(0, 15)), $urandom);
            1: queue_beat(ibmw_pkg::OP_LOAD, 4'($urandom_range(0, 15)), reply_word());
            2: queue_beat(OP_UNUSED, 4'($urandom_range(0, 15)), $urandom);
            default: queue_beat(ibmw_pkg::OP_REPLY, 4'($urandom_range(0, 15)), reply_word());
         endcase
      end
   endtask

   task automatic gen_random();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         gen_walk();
      else if (r < 82)
         queue_beat(ibmw_pkg::OP_LOAD, 4'($urandom_range(0, 15)),
                    ($urandom_range(0, 7) == 0) ? 32'd0 : reply_word());
      else if (r < 94)
         queue_beat(ibmw_pkg::OP_REPLY, 4'($urandom_range(0, 15)), $urandom);
      else
         queue_beat(OP_UNUSED, 4'($urandom_range(0, 15)), $urandom);
   endtask

   logic [1:0] size_plan [10] = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};

   initial begin
      int unsigned target;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cfg_write(2'd0);
      // every slot is loaded before any lookup can read it
      queue_beat(ibmw_pkg::OP_LOAD, 4'd0, 32'hFFFF_FFFF);
      queue_beat(ibmw_pkg::OP_LOAD, 4'd1, 32'd0);
      for (int i = 2; i < DIRECT_PTRS; i++)
         queue_beat(ibmw_pkg::OP_LOAD, 4'(i), $urandom | 32'd1);
      queue_beat(ibmw_pkg::OP_LOAD, ibmw_pkg::SLOT_SINGLE, 32'h0000_1000);
      queue_beat(ibmw_pkg::OP_LOAD, ibmw_pkg::SLOT_DOUBLE, $urandom | 32'h10);
      queue_beat(ibmw_pkg::OP_LOAD, ibmw_pkg::SLOT_TRIPLE, 32'h8000_0001);
      queue_beat(ibmw_pkg::OP_LOAD, SLOT_UNUSED, 32'h5A5A_5A5A);
      queue_beat(OP_UNUSED, 4'd15, 32'hFFFF_FFFF);
      queue_beat(ibmw_pkg::OP_REPLY, 4'd0, 32'h1234_5678);               // reply while idle
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, 32'd0);
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, 32'd1);                       // zero direct pointer
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, DIRECT_PTRS - 1);
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, DIRECT_PTRS);                 // single indirect
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, 32'd5);                       // lookup while walking
      queue_beat(ibmw_pkg::OP_LOAD, 4'd3, 32'h0000_0042);                 // load while walking
      queue_beat(ibmw_pkg::OP_REPLY, 4'd0, 32'hFFFF_FFFF);
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, 32'hFFFF_FFFF);               // beyond reach
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, DIRECT_PTRS + 256 + 65536);   // first triple
      queue_beat(ibmw_pkg::OP_REPLY, 4'd0, 32'd0);                        // zero reply
      // leave a double walk open so the next size applies mid-walk
      queue_beat(ibmw_pkg::OP_LOOKUP, 4'd0, DIRECT_PTRS + 256 + 300);
      drain();

      foreach (size_plan[p]) begin
         cfg_write(size_plan[p]);
         target = beats_made + PHASE_BEATS;
         while (beats_made < target) gen_random();
         drain();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
